// ----- design/gbr_pkg.sv -----
package gbr_pkg;

    localparam int GBR_CELL_SIZE  = 16;
    localparam int GBR_GRID_CELLS = 16;
    localparam int GBR_LEVELS     = 256;

    localparam int PIX_W  = 8;
    localparam int SUM_W  = 16;
    localparam int DIST_W = 24;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_QUERY   = 2'd1,
        ACT_RESTART = 2'd2
    } t_action;

endpackage

// ----- design/gbr_in_if.sv -----
interface gbr_in_if
    import gbr_pkg::*;
;
    logic    valid;
    logic    ready;
    t_action action;
    logic [7:0] pixel;
    logic [7:0] level;

    modport source (output valid, action, pixel, level, input ready);
    modport sink (input valid, action, pixel, level, output ready);
endinterface

// ----- design/gbr_out_if.sv -----
interface gbr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  glyph_index;
    logic [3:0]  row;
    logic [63:0] pixels_low;
    logic [63:0] pixels_high;
    logic        last;

    modport source (output valid, glyph_index, row, pixels_low, pixels_high, last,
                    input ready);
    modport sink (input valid, glyph_index, row, pixels_low, pixels_high, last,
                  output ready);
endinterface

// ----- design/gbr_ram.sv -----
module gbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/glyph_brightness_ramp_builder.sv -----
// load and restart items: one per cycle, no result
// query item: scan of all cell sums through the sum memory, then a pipeline drain,
//   then per row an atlas lane read (S_RD, S_LOAD), S_LOAD waiting on a free output
// input is held off from query accept until the last row sits in the output register
// reset (synchronous, active low): cell sums read as zero, load position zero,
//   atlas contents undefined until loaded, no clearing pass
module glyph_brightness_ramp_builder
    import gbr_pkg::*;
#(
    parameter int CELL_SIZE  = GBR_CELL_SIZE,
    parameter int GRID_CELLS = GBR_GRID_CELLS,
    parameter int LEVELS     = GBR_LEVELS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    gbr_in_if.sink    i_in,
    gbr_out_if.source o_out
);

    localparam int NC      = GRID_CELLS * GRID_CELLS;
    localparam int CLW     = $clog2(NC);
    localparam int RW      = $clog2(GRID_CELLS);
    localparam int LW      = $clog2(CELL_SIZE);
    localparam int DEPTH_L = CELL_SIZE * GRID_CELLS * GRID_CELLS;
    localparam int AW      = $clog2(DEPTH_L);
    localparam int LMAX    = LEVELS - 1;
    localparam int TGT_MUL = 255 * CELL_SIZE * CELL_SIZE;
    localparam int ROW_STRIDE = CELL_SIZE * GRID_CELLS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_RD,
        S_LOAD
    } t_state;

    t_state r_state;

    // load position counters
    logic [LW-1:0] r_lane;
    logic [RW-1:0] r_cx;
    logic [LW-1:0] r_ly;
    logic [RW-1:0] r_cy;
    logic [AW-1:0] r_waddr;

    // sum update pipeline
    logic             r_l1_v;
    logic [CLW-1:0]   r_l1_cell;
    logic [PIX_W-1:0] r_l1_px;
    logic             r_fw_v;
    logic [CLW-1:0]   r_fw_cell;
    logic [SUM_W-1:0] r_fw_sum;
    logic [NC-1:0]    r_sum_vld;

    // scan pipeline
    logic [DIST_W-1:0] r_target;
    logic [CLW-1:0]    r_scan_i;
    logic [RW-1:0]     r_scan_r;
    logic [RW-1:0]     r_scan_c;
    logic              r_p1_v;
    logic [CLW-1:0]    r_p1_i;
    logic [RW-1:0]     r_p1_r;
    logic [RW-1:0]     r_p1_c;
    logic              r_p2_v;
    logic [DIST_W-1:0] r_p2_d;
    logic [CLW-1:0]    r_p2_i;
    logic [RW-1:0]     r_p2_r;
    logic [RW-1:0]     r_p2_c;
    logic [DIST_W-1:0] r_best_d;
    logic [CLW-1:0]    r_best_i;
    logic [RW-1:0]     r_best_r;
    logic [RW-1:0]     r_best_c;

    // emit
    logic [AW-1:0] r_raddr;
    logic [3:0]    r_row;
    logic          r_out_v;
    logic [7:0]    r_out_idx;
    logic [3:0]    r_out_row;
    logic [63:0]   r_out_lo;
    logic [63:0]   r_out_hi;
    logic          r_out_last;

    logic             w_acc;
    logic [CLW-1:0]   w_load_cell;
    logic [CLW-1:0]   w_sum_raddr;
    logic [SUM_W-1:0] w_sum_rd;
    logic [SUM_W-1:0] n_old;
    logic [SUM_W:0]   n_add;
    logic [SUM_W-1:0] n_sum;
    logic [SUM_W-1:0] n_scan_sum;
    logic [DIST_W-1:0] n_v;
    logic [DIST_W-1:0] n_d;
    logic [7:0]       n_lvl;
    logic [PIX_W-1:0] w_lane_rd [CELL_SIZE];
    logic [PIX_W-1:0] w_bytes [16];
    logic [63:0]      n_lo;
    logic [63:0]      n_hi;
    logic             w_out_free;

    assign w_acc       = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_load_cell = CLW'(CLW'(r_cy) * CLW'(GRID_CELLS) + CLW'(r_cx));
    assign w_sum_raddr = (r_state == S_SCAN) ? r_scan_i : w_load_cell;
    assign w_out_free  = !r_out_v || o_out.ready;

    gbr_ram #(.WIDTH(SUM_W), .DEPTH(NC)) u_sums (
        .i_clk   (i_clk),
        .i_we    (r_l1_v),
        .i_waddr (r_l1_cell),
        .i_wdata (n_sum),
        .i_raddr (w_sum_raddr),
        .o_rdata (w_sum_rd)
    );

    genvar g;
    generate
        for (g = 0; g < CELL_SIZE; g++) begin : g_lane
            gbr_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH_L))
            u_lane (
                .i_clk   (i_clk),
                .i_we    (w_acc && i_in.action == ACT_LOAD && r_lane == LW'(g)),
                .i_waddr (r_waddr),
                .i_wdata (i_in.pixel),
                .i_raddr (r_raddr),
                .o_rdata (w_lane_rd[g])
            );
        end
        for (g = 0; g < 16; g++) begin : g_byte
            if (g < CELL_SIZE) begin : g_used
                assign w_bytes[g] = w_lane_rd[g];
            end else begin : g_zero
                assign w_bytes[g] = '0;
            end
        end
    endgenerate

    always_comb begin
        n_lo = '0;
        n_hi = '0;
        for (int a = 0; a < 8; a++) begin
            n_lo[8*a +: 8] = w_bytes[a];
            n_hi[8*a +: 8] = w_bytes[a+8];
        end
    end

    // sum update with forwarding of the previous write
    always_comb begin
        if (r_fw_v && r_fw_cell == r_l1_cell) begin
            n_old = r_fw_sum;
        end else if (r_sum_vld[r_l1_cell]) begin
            n_old = w_sum_rd;
        end else begin
            n_old = '0;
        end
        n_add = {1'b0, n_old} + (SUM_W+1)'(r_l1_px);
        n_sum = n_add[SUM_W] ? '1 : n_add[SUM_W-1:0];
    end

    always_comb begin
        n_scan_sum = r_sum_vld[r_p1_i] ? w_sum_rd : '0;
        n_v = DIST_W'(n_scan_sum) * DIST_W'(LMAX);
        n_d = (n_v > r_target) ? (n_v - r_target) : (r_target - n_v);
        n_lvl = (int'(i_in.level) > LMAX) ? 8'(LMAX) : i_in.level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_lane    <= '0;
            r_cx      <= '0;
            r_ly      <= '0;
            r_cy      <= '0;
            r_waddr   <= '0;
            r_l1_v    <= 1'b0;
            r_fw_v    <= 1'b0;
            r_sum_vld <= '0;
            r_p1_v    <= 1'b0;
            r_p2_v    <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_l1_v <= 1'b0;
            r_p1_v <= 1'b0;
            r_p2_v <= r_p1_v;
            if (o_out.ready) begin
                r_out_v <= 1'b0;
            end

            // restart drops every sum, including one being written now
            if (w_acc && i_in.action == ACT_RESTART) begin
                r_fw_v    <= 1'b0;
                r_sum_vld <= '0;
            end else if (r_l1_v) begin
                r_fw_v               <= 1'b1;
                r_fw_cell            <= r_l1_cell;
                r_fw_sum             <= n_sum;
                r_sum_vld[r_l1_cell] <= 1'b1;
            end

            if (r_p1_v) begin
                r_p2_d <= n_d;
                r_p2_i <= r_p1_i;
                r_p2_r <= r_p1_r;
                r_p2_c <= r_p1_c;
            end
            if (r_p2_v && (r_p2_i == '0 || r_p2_d < r_best_d)) begin
                r_best_d <= r_p2_d;
                r_best_i <= r_p2_i;
                r_best_r <= r_p2_r;
                r_best_c <= r_p2_c;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        case (i_in.action)
                            ACT_LOAD: begin
                                r_l1_v    <= 1'b1;
                                r_l1_cell <= w_load_cell;
                                r_l1_px   <= i_in.pixel;
                                if (r_lane != LW'(CELL_SIZE - 1)) begin
                                    r_lane <= r_lane + 1'b1;
                                end else begin
                                    r_lane  <= '0;
                                    r_waddr <= (r_waddr == AW'(DEPTH_L - 1)) ?
                                               '0 : r_waddr + 1'b1;
                                    if (r_cx != RW'(GRID_CELLS - 1)) begin
                                        r_cx <= r_cx + 1'b1;
                                    end else begin
                                        r_cx <= '0;
                                        if (r_ly != LW'(CELL_SIZE - 1)) begin
                                            r_ly <= r_ly + 1'b1;
                                        end else begin
                                            r_ly <= '0;
                                            r_cy <= (r_cy == RW'(GRID_CELLS - 1)) ?
                                                    '0 : r_cy + 1'b1;
                                        end
                                    end
                                end
                            end
                            ACT_QUERY: begin
                                r_target <= DIST_W'(n_lvl) * DIST_W'(TGT_MUL);
                                r_scan_i <= '0;
                                r_scan_r <= '0;
                                r_scan_c <= '0;
                                r_state  <= S_SCAN;
                            end
                            ACT_RESTART: begin
                                r_lane  <= '0;
                                r_cx    <= '0;
                                r_ly    <= '0;
                                r_cy    <= '0;
                                r_waddr <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_p1_v   <= 1'b1;
                    r_p1_i   <= r_scan_i;
                    r_p1_r   <= r_scan_r;
                    r_p1_c   <= r_scan_c;
                    r_scan_i <= r_scan_i + 1'b1;
                    if (r_scan_c != RW'(GRID_CELLS - 1)) begin
                        r_scan_c <= r_scan_c + 1'b1;
                    end else begin
                        r_scan_c <= '0;
                        r_scan_r <= r_scan_r + 1'b1;
                    end
                    if (r_scan_i == CLW'(NC - 1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_p1_v && !r_p2_v) begin
                        r_raddr <= AW'(AW'(r_best_r) * AW'(ROW_STRIDE) + AW'(r_best_c));
                        r_row   <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (w_out_free) begin
                        r_out_v    <= 1'b1;
                        r_out_idx  <= 8'(r_best_i);
                        r_out_row  <= r_row;
                        r_out_lo   <= n_lo;
                        r_out_hi   <= n_hi;
                        r_out_last <= (r_row == 4'(CELL_SIZE - 1));
                        if (r_row == 4'(CELL_SIZE - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_row   <= r_row + 1'b1;
                            r_raddr <= r_raddr + AW'(GRID_CELLS);
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.glyph_index = r_out_idx;
    assign o_out.row         = r_out_row;
    assign o_out.pixels_low  = r_out_lo;
    assign o_out.pixels_high = r_out_hi;
    assign o_out.last        = r_out_last;

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_l1_v |-> r_state == S_IDLE)
        else $error("sum update overlaps a scan");

    a_scan_quiet_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !r_p1_v && !r_p2_v)
        else $error("input open while scan pipeline busy");

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.last |-> o_out.row == 4'(CELL_SIZE - 1))
        else $error("last flag on wrong row");

    a_index_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.last |=> $stable(o_out.glyph_index))
        else $error("glyph index changed within a glyph");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import gbr_pkg::*;

    localparam int TILE          = GBR_CELL_SIZE;
    localparam int GRID          = GBR_GRID_CELLS;
    localparam int QUERY_LEVELS  = GBR_LEVELS;
    localparam int ATLAS_W       = TILE * GRID;
    localparam int ATLAS_PIX     = ATLAS_W * ATLAS_W;
    localparam int TILES         = GRID * GRID;
    localparam int SUM_MAX       = 65535;
    localparam int RAND_FIELD    = -1;
    localparam int RANDOM_ITEMS  = 500;
    localparam int HOLD_AT_QUERY = 14;
    localparam int HOLD_CYCLES   = 700;
    localparam int DRAIN_CYCLES  = 300;

    localparam logic [1:0] ACT_IGNORED_CODE = 2'd3;

    typedef struct {
        t_action    action;
        logic [7:0] pixel;
        logic [7:0] level;
        bit         settle;
    } t_atlas_cmd;

    typedef struct {
        logic [7:0]  glyph_index;
        logic [3:0]  row;
        logic [63:0] pixels_low;
        logic [63:0] pixels_high;
        logic        last;
    } t_glyph_row;

    typedef enum {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PERIODIC
    } t_sink_mode;

    logic i_clk;
    logic i_rst_n;

    gbr_in_if  in_if ();
    gbr_out_if out_if ();

    glyph_brightness_ramp_builder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    // shadow of the block state
    logic [7:0]  atlas_img [ATLAS_PIX];
    logic [15:0] tile_sum [TILES] = '{default: '0};
    int          load_pos = 0;

    t_atlas_cmd  cmd_backlog [$];
    t_glyph_row  glyph_rows_due [$];
    t_atlas_cmd  cur_cmd;
    int          rows_predicted = 0;
    int          rows_checked = 0;
    int          queries_taken = 0;
    int          err_cnt = 0;
    int          burst_left;
    int          gap_left;
    int          hold_left;
    bit          hold_done;
    int          mode_left;
    int          sink_tick;
    t_sink_mode  sink_mode;

    function automatic int tile_of(int pos);
        return ((pos / ATLAS_W) / TILE) * GRID + (pos % ATLAS_W) / TILE;
    endfunction

    // exact integer form of the closest normalized mean, first tile wins ties
    function automatic int closest_glyph(logic [7:0] lvl);
        longint lv;
        longint goal;
        longint v;
        longint delta;
        longint best_delta;
        int     best;
        lv = lvl;
        if (lv > QUERY_LEVELS - 1) begin
            lv = QUERY_LEVELS - 1;
        end
        goal = lv * 255 * TILE * TILE;
        best = 0;
        best_delta = 0;
        for (int i = 0; i < TILES; i++) begin
            v = longint'(tile_sum[i]) * (QUERY_LEVELS - 1);
            delta = (v > goal) ? v - goal : goal - v;
            if (i == 0 || delta < best_delta) begin
                best_delta = delta;
                best = i;
            end
        end
        return best;
    endfunction

    task automatic absorb_item(input t_atlas_cmd it);
        int         pos;
        int         t;
        int         s;
        int         pick;
        int         base;
        t_glyph_row r;
        case (it.action)
            ACT_LOAD: begin
                pos = load_pos;
                if (pos >= ATLAS_PIX) begin
                    pos = 0;
                end
                t = tile_of(pos);
                atlas_img[pos] = it.pixel;
                s = int'(tile_sum[t]) + int'(it.pixel);
                if (s > SUM_MAX) begin
                    s = SUM_MAX;
                end
                tile_sum[t] = s[15:0];
                pos++;
                if (pos >= ATLAS_PIX) begin
                    pos = 0;
                end
                load_pos = pos;
            end
            ACT_RESTART: begin
                foreach (tile_sum[i]) begin
                    tile_sum[i] = '0;
                end
                load_pos = 0;
            end
            ACT_QUERY: begin
                pick = closest_glyph(it.level);
                base = (pick / GRID) * ATLAS_W * TILE + (pick % GRID) * TILE;
                for (int b = 0; b < TILE; b++) begin
                    r.glyph_index = pick[7:0];
                    r.row = b[3:0];
                    r.pixels_low = '0;
                    r.pixels_high = '0;
                    for (int a = 0; a < TILE; a++) begin
                        if (a < 8) begin
                            r.pixels_low[8 * a +: 8] =
                                atlas_img[(base + ATLAS_W * b + a) % ATLAS_PIX];
                        end else begin
                            r.pixels_high[8 * (a - 8) +: 8] =
                                atlas_img[(base + ATLAS_W * b + a) % ATLAS_PIX];
                        end
                    end
                    r.last = (b == TILE - 1);
                    glyph_rows_due.push_back(r);
                    rows_predicted++;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic queue_cmd(input t_action act, input int px, input int lvl, input bit settle = 0);
        t_atlas_cmd c;
        c.action = act;
        c.pixel = (px < 0) ? 8'($urandom_range(0, 255)) : 8'(px);
        c.level = (lvl < 0) ? 8'($urandom_range(0, 255)) : 8'(lvl);
        c.settle = settle;
        cmd_backlog.push_back(c);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            in_if.action <= ACT_LOAD;
            in_if.pixel <= '0;
            in_if.level <= '0;
            burst_left = 1;
            gap_left = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                absorb_item(cur_cmd);
                if (cur_cmd.action == ACT_QUERY) begin
                    queries_taken <= queries_taken + 1;
                end
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (cmd_backlog.size() != 0 &&
                             (!cmd_backlog[0].settle || rows_predicted == rows_checked)) begin
                    cur_cmd = cmd_backlog.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.action <= cur_cmd.action;
                    in_if.pixel <= cur_cmd.pixel;
                    in_if.level <= cur_cmd.level;
                    burst_left--;
                    if (burst_left == 0) begin
                        gap_left = $urandom_range(0, 3);
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                                 : $urandom_range(1, 16);
                    end
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver and row checker
    always @(posedge i_clk) begin
        t_glyph_row want;
        logic       rdy;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
            mode_left = 0;
            sink_tick = 0;
            sink_mode = SINK_OPEN;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (glyph_rows_due.size() == 0) begin
                    $error("unexpected row: glyph_index %0d row %0d",
                           out_if.glyph_index, out_if.row);
                    err_cnt++;
                end else begin
                    want = glyph_rows_due.pop_front();
                    rows_checked <= rows_checked + 1;
                    if (out_if.glyph_index !== want.glyph_index) begin
                        $error("glyph_index mismatch: expected %0d actual %0d",
                               want.glyph_index, out_if.glyph_index);
                        err_cnt++;
                    end
                    if (out_if.row !== want.row) begin
                        $error("row mismatch: expected %0d actual %0d", want.row, out_if.row);
                        err_cnt++;
                    end
                    if (out_if.pixels_low !== want.pixels_low) begin
                        $error("pixels_low mismatch: expected %h actual %h",
                               want.pixels_low, out_if.pixels_low);
                        err_cnt++;
                    end
                    if (out_if.pixels_high !== want.pixels_high) begin
                        $error("pixels_high mismatch: expected %h actual %h",
                               want.pixels_high, out_if.pixels_high);
                        err_cnt++;
                    end
                    if (out_if.last !== want.last) begin
                        $error("last mismatch: expected %0d actual %0d", want.last, out_if.last);
                        err_cnt++;
                    end
                end
            end
            // one long hold-off so the block backs up into its input
            if (!hold_done && queries_taken == HOLD_AT_QUERY) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    sink_mode = t_sink_mode'($urandom_range(0, 2));
                    mode_left = $urandom_range(32, 400);
                end else begin
                    mode_left--;
                end
                case (sink_mode)
                    SINK_OPEN:     rdy = 1'b1;
                    SINK_RANDOM:   rdy = ($urandom_range(0, 2) != 0);
                    SINK_PERIODIC: rdy = ((sink_tick % 5) < 3);
                    default:       rdy = 1'b1;
                endcase
            end
            out_if.ready <= rdy;
            sink_tick++;
        end
    end

    initial begin
        int tone_lo [TILES];
        int tone_hi [TILES];
        int t;
        int px;
        int fed;
        int n_load;
        int n_query;

        // whole atlas first: tile 0 all 255, tiles 1 and last all 0, each other tile with its own tone range
        for (int i = 0; i < TILES; i++) begin
            tone_lo[i] = $urandom_range(0, 255);
            tone_hi[i] = ($urandom_range(0, 3) == 0) ? tone_lo[i]
                                                     : $urandom_range(tone_lo[i], 255);
        end
        for (int p = 0; p < ATLAS_PIX; p++) begin
            t = tile_of(p);
            if (t == 0) begin
                px = 255;
            end else if (t == 1 || t == TILES - 1) begin
                px = 0;
            end else begin
                px = $urandom_range(tone_lo[t], tone_hi[t]);
            end
            queue_cmd(ACT_LOAD, px, RAND_FIELD);
        end

        // wrapped loads push tile 0 into saturation
        repeat (TILE) queue_cmd(ACT_LOAD, 255, RAND_FIELD);
        queue_cmd(ACT_QUERY, RAND_FIELD, 255, 1'b1);
        queue_cmd(ACT_QUERY, RAND_FIELD, 0);
        queue_cmd(ACT_QUERY, RAND_FIELD, 128);
        queue_cmd(ACT_QUERY, RAND_FIELD, 1);
        queue_cmd(ACT_QUERY, RAND_FIELD, 254);
        queue_cmd(t_action'(ACT_IGNORED_CODE), RAND_FIELD, RAND_FIELD);
        queue_cmd(ACT_QUERY, RAND_FIELD, RAND_FIELD);
        queue_cmd(ACT_RESTART, RAND_FIELD, RAND_FIELD);
        // all sums zero: every tile ties
        queue_cmd(ACT_QUERY, RAND_FIELD, 0);
        queue_cmd(ACT_QUERY, RAND_FIELD, 255);
        repeat (20) queue_cmd(ACT_LOAD, 255, RAND_FIELD);
        queue_cmd(ACT_QUERY, RAND_FIELD, 1);
        queue_cmd(ACT_QUERY, RAND_FIELD, 16);
        queue_cmd(ACT_RESTART, RAND_FIELD, RAND_FIELD, 1'b1);

        fed = 0;
        while (fed < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                queue_cmd(ACT_RESTART, RAND_FIELD, RAND_FIELD, $urandom_range(0, 5) == 0);
                fed++;
            end
            n_load = ($urandom_range(0, 4) == 0) ? $urandom_range(32, 200) : $urandom_range(0, 16);
            repeat (n_load) begin
                queue_cmd(ACT_LOAD, ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 255),
                          RAND_FIELD);
                fed++;
            end
            n_query = $urandom_range(1, 4);
            repeat (n_query) begin
                if ($urandom_range(0, 9) == 0) begin
                    queue_cmd(t_action'(ACT_IGNORED_CODE), RAND_FIELD, RAND_FIELD);
                end
                queue_cmd(ACT_QUERY, RAND_FIELD,
                          ($urandom_range(0, 1) == 0) ? $urandom_range(0, 16)
                                                      : $urandom_range(0, 255),
                          $urandom_range(0, 9) == 0);
                fed++;
            end
        end

        while (cmd_backlog.size() != 0 || in_if.valid) @(posedge i_clk);
        while (rows_checked != rows_predicted) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (glyph_rows_due.size() != 0) begin
            $error("%0d expected rows never arrived", glyph_rows_due.size());
        end
        if (err_cnt == 0 && glyph_rows_due.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/gbr_pkg.sv
design/gbr_in_if.sv
design/gbr_out_if.sv
design/gbr_ram.sv
design/glyph_brightness_ramp_builder.sv
test/testbench.sv
